FILE: sv/pkmd_pkg.sv
// shared types and constants for the parallel keyboard and mouse decoder
package pkmd_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_KBD_EN   = 1'b0;
  localparam logic [0:0] REG_MOUSE_EN = 1'b1;

  // mouse button sample marker in the high nibble
  localparam logic [3:0] BTN_NIBBLE = 4'h8;

  // request queue depth between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // output byte slots within one job
  localparam logic [1:0] SLOT_KBD  = 2'd0;
  localparam logic [1:0] SLOT_BTN  = 2'd1;
  localparam logic [1:0] SLOT_DELX = 2'd2;
  localparam logic [1:0] SLOT_DELY = 2'd3;

  // mouse report phase, one-hot
  typedef enum logic [2:0] {
    PH_DELY   = 3'b001,
    PH_BUTTON = 3'b010,
    PH_DELX   = 3'b100
  } phase_t;

  // one classified request: keyboard byte and/or a three-byte mouse report
  typedef struct packed {
    logic       kbd_valid;
    logic [7:0] kbd_code;
    logic       ms_valid;
    logic [7:0] button;
    logic [7:0] delta_x;
    logic [7:0] delta_y;
  } job_t;

endpackage

FILE: sv/pkmd_front.sv
// front end: takes port samples, tracks change and phase state, builds jobs
module pkmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [0:0]        cfg_addr,
  input  logic [0:0]        cfg_wdata,
  input  logic              accept,
  input  logic [7:0]        keyboard_code,
  input  logic [7:0]        mouse_raw,
  output logic              push,
  output pkmd_pkg::job_t    job
);
  import pkmd_pkg::*;

  logic       kbd_en;
  logic       ms_en;
  logic [7:0] prev_kbd;
  logic [7:0] prev_ms;
  phase_t     phase;
  logic [7:0] button_value;
  logic [7:0] reported_button;
  logic [6:0] pending_dy;

  phase_t     phase_next;
  logic [7:0] button_next;
  logic [7:0] reported_next;
  logic [6:0] pending_dy_next;
  logic       ms_use;
  logic       is_btn;
  logic [7:0] btn_cur;
  logic [7:0] m;
  logic [7:0] dy;
  phase_t     phase_eff;

  // decode one sample against the stored state
  always_comb begin
    ms_use          = (mouse_raw != prev_ms) && ms_en;
    is_btn          = (mouse_raw[7:4] == BTN_NIBBLE);
    btn_cur         = is_btn ? {5'b10000, mouse_raw[3:1]} : button_value;
    m               = is_btn ? mouse_raw : {mouse_raw[7], mouse_raw[7:1]};
    dy              = {pending_dy[6], pending_dy};
    phase_eff       = is_btn ? PH_BUTTON : phase;
    phase_next      = phase;
    button_next     = button_value;
    reported_next   = reported_button;
    pending_dy_next = pending_dy;
    job.kbd_valid   = (keyboard_code != prev_kbd) && kbd_en;
    job.kbd_code    = keyboard_code;
    job.ms_valid    = 1'b0;
    job.button      = btn_cur;
    job.delta_x     = m;
    job.delta_y     = dy;
    if (ms_use) begin
      button_next = btn_cur;
      unique case (phase_eff)
        PH_BUTTON: phase_next = PH_DELX;
        PH_DELX: begin
          phase_next = PH_DELY;
          if (!(btn_cur == reported_button && m == 8'd0 && dy == 8'd0)) begin
            job.ms_valid    = 1'b1;
            reported_next   = btn_cur;
            pending_dy_next = m[6:0];
          end
        end
        default: begin
          phase_next      = PH_DELY;
          pending_dy_next = m[6:0];
        end
      endcase
    end
    push = accept && (job.kbd_valid || job.ms_valid);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kbd_en <= 1'b0;
      ms_en  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_KBD_EN:   kbd_en <= cfg_wdata[0];
        REG_MOUSE_EN: ms_en  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kbd        <= 8'd0;
      prev_ms         <= 8'd0;
      phase           <= PH_DELY;
      button_value    <= 8'd0;
      reported_button <= 8'd0;
      pending_dy      <= 7'd0;
    end else if (accept) begin
      prev_kbd        <= keyboard_code;
      prev_ms         <= mouse_raw;
      phase           <= phase_next;
      button_value    <= button_next;
      reported_button <= reported_next;
      pending_dy      <= pending_dy_next;
    end
  end

endmodule

FILE: sv/pkmd_fifo.sv
// short request queue between front end and serializer
module pkmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pkmd_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output pkmd_pkg::job_t pop_data
);
  import pkmd_pkg::*;

  job_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/pkmd_back.sv
// back end: serializes one job into result bytes on the output stream
module pkmd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pkmd_pkg::job_t q_data,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tuser,
  output logic           m_tlast
);
  import pkmd_pkg::*;

  job_t       cur;
  logic       busy;
  logic [1:0] pos;
  logic       fire;
  logic       last;
  logic       load;

  // end of job and reload control
  always_comb begin
    fire  = busy && m_tready;
    last  = cur.ms_valid ? (pos == SLOT_DELY) : 1'b1;
    load  = !busy || (fire && last);
    q_pop = load && q_valid;
  end

  // byte select for the current slot
  always_comb begin
    unique case (pos)
      SLOT_KBD:  m_tdata = cur.kbd_code;
      SLOT_BTN:  m_tdata = cur.button;
      SLOT_DELX: m_tdata = cur.delta_x;
      SLOT_DELY: m_tdata = cur.delta_y;
      default:   m_tdata = cur.kbd_code;
    endcase
    m_tuser  = (pos != SLOT_KBD);
    m_tlast  = last;
    m_tvalid = busy;
  end

  // job register and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= SLOT_KBD;
    end else if (q_pop) begin
      busy <= 1'b1;
      pos  <= q_data.kbd_valid ? SLOT_KBD : SLOT_BTN;
    end else if (fire && last) begin
      busy <= 1'b0;
    end else if (fire) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule

FILE: sv/parallel_kbd_mouse_decoder_unit.sv
// Parallel keyboard and mouse decoder, top level.
// Input stream: one request per port sample, s_tdata = keyboard byte and mouse byte.
// A changed keyboard byte is emitted when the keyboard is enabled; changed mouse
// bytes are decoded when the mouse is enabled and, after a delta X, produce a
// three-byte report (button, delta X, delta Y) unless nothing changed.
// Output stream: one byte per transfer, m_tuser gives the channel (0 keyboard,
// 1 mouse), m_tlast marks the final byte caused by one sample.
// The front end takes a sample and pushes a job into a four-entry queue; the
// serializer sends one byte per cycle while m_tready is high, from a job register
// loaded from the queue, and a sample yields 0 to 4 output bytes.
// Samples are taken every cycle while the queue has room; the sustained rate is
// set by the output port at one byte per cycle while m_tready is high.
// Configuration: cfg_wr_en with cfg_addr 0 (keyboard enable) or 1 (mouse
// enable), bit 0 of cfg_wdata; write only while the block is idle.
// Reset clears all history, the phase (delta Y), both enables and the queue.
// When the receiver stalls, the current byte holds and the queue fills; then
// s_tready drops until a slot frees up.
module parallel_kbd_mouse_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_addr,
  input  logic [0:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] keyboard_code, [15:8] mouse_raw
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] data_byte
  output logic        m_tuser,   // [0] channel
  output logic        m_tlast
);
  import pkmd_pkg::*;

  logic q_full;
  logic accept;
  logic push;
  job_t push_job;
  logic q_valid;
  job_t q_data;
  logic q_pop;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  // sample classification and state tracking
  pkmd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .keyboard_code (s_tdata[7:0]),
    .mouse_raw     (s_tdata[15:8]),
    .push          (push),
    .job           (push_job)
  );

  // request queue
  pkmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // byte serializer
  pkmd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: verif/parallel_kbd_mouse_decoder_unit_tb.sv
// testbench for the parallel keyboard and mouse decoder: random port samples, byte-level checks
`timescale 1ns / 1ps

module parallel_kbd_mouse_decoder_unit_tb;
  import pkmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PCT = 34;
  localparam int RANDOM_PER_SETTING = 40;

  // directed port samples, {mouse_raw, keyboard_code}
  localparam logic [15:0] DIRECTED [20] = '{
    16'h0000,  // nothing changed
    16'h7EFF,  // key 0xff, largest positive delta y
    16'h8801,  // key 0x01, button sample
    16'h9001,  // negative delta x, full report
    16'h8F80,  // key 0x80, button sample with every low bit set
    16'h027F,  // key plus report: four bytes from one sample
    16'h817F,  // button with no buttons pressed
    16'h007F,  // zero delta x, report still carries delta y
    16'h807F,  // same button again
    16'h017F,  // zero deltas and unchanged button: report dropped
    16'h007F,  // delta y of zero
    16'h007F,  // repeated byte is ignored
    16'hFF00,  // minus one as delta y
    16'h8B00,  // button sample
    16'h8C00,  // button sample right after another one
    16'hF000,  // negative delta x
    16'hF055,  // keyboard only
    16'h70AA,  // delta y
    16'h8155,  // button
    16'h01AA   // zero delta x with nonzero delta y
  };

  // predicts output bytes from accepted port samples and checks them in order
  class decode_scoreboard;
    typedef struct packed {
      logic       channel;
      logic [7:0] data;
      logic       last;
    } out_byte_t;

    bit         kbd_on;
    bit         mouse_on;
    logic [7:0] last_kbd;
    logic [7:0] last_mouse;
    logic [7:0] button;
    logic [7:0] shown_button;
    logic [6:0] held_dy;
    phase_t     ph;
    out_byte_t  pending_bytes[$];
    int         errors;
    int         checked;
    int         reports;
    int         dropped;

    function new();
      kbd_on = 0;
      mouse_on = 0;
      last_kbd = '0;
      last_mouse = '0;
      button = '0;
      shown_button = '0;
      held_dy = '0;
      ph = PH_DELY;
      errors = 0;
      checked = 0;
      reports = 0;
      dropped = 0;
    endfunction

    function void set_register(logic [0:0] idx, logic [0:0] val);
      if (idx == REG_KBD_EN) begin
        kbd_on = val[0];
      end else begin
        mouse_on = val[0];
      end
    endfunction

    // one accepted port sample
    function void take_sample(logic [7:0] kb, logic [7:0] ms);
      out_byte_t  run[$];
      logic [7:0] m;
      logic [7:0] dy;
      if (kb != last_kbd) begin
        last_kbd = kb;
        if (kbd_on) run.push_back('{1'b0, kb, 1'b0});
      end
      if (ms != last_mouse) begin
        last_mouse = ms;
        if (mouse_on) begin
          // delta is bits 7..1 with sign kept
          m = {ms[7], ms[7:1]};
          if (ms[7:4] == BTN_NIBBLE) begin
            ph = PH_BUTTON;
            button = {BTN_NIBBLE, 1'b0, ms[3:1]};
          end
          case (ph)
            PH_BUTTON: begin
              ph = PH_DELX;
            end
            PH_DELX: begin
              dy = {held_dy[6], held_dy};
              ph = PH_DELY;
              // report only when something changed
              if (!(button == shown_button && m == 8'h00 && dy == 8'h00)) begin
                shown_button = button;
                run.push_back('{1'b1, button, 1'b0});
                run.push_back('{1'b1, m, 1'b0});
                run.push_back('{1'b1, dy, 1'b0});
                held_dy = m[6:0];
                reports++;
              end else begin
                dropped++;
              end
            end
            default: begin
              ph = PH_DELY;
              held_dy = m[6:0];
            end
          endcase
        end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) pending_bytes.push_back(run[i]);
    endfunction

    // one accepted output byte
    function void match_byte(logic ch, logic [7:0] data, logic last);
      out_byte_t want;
      checked++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual chan %0b data %02h last %0b",
                 $time, ch, data, last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (ch !== want.channel) begin
        $display("%0t: channel mismatch: expected %0b, actual %0b", $time, want.channel, ch);
        errors++;
      end
      if (data !== want.data) begin
        $display("%0t: data mismatch: expected %02h, actual %02h", $time, want.data, data);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: tlast mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_addr = REG_KBD_EN;
  logic [0:0]  cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  decode_scoreboard sb = new();
  bit          steady = 1'b0;
  int          cycles = 0;
  int          samples = 0;
  int          settings = 0;
  int          seq_pos = 0;
  logic [7:0]  kb_sent = '0;

  parallel_kbd_mouse_decoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_byte(m_tuser, m_tdata, m_tlast);
  end

  // send one port sample and wait until it is taken
  task automatic send_sample(logic [7:0] kb, logic [7:0] ms);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ms, kb};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.take_sample(kb, ms);
    kb_sent = kb;
    samples++;
  endtask

  // let the block drain, then write both enables
  task automatic set_enables(logic [0:0] kbd, logic [0:0] mouse);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_KBD_EN;
    cfg_wdata <= kbd;
    @(posedge clk);
    sb.set_register(REG_KBD_EN, kbd);
    cfg_addr <= REG_MOUSE_EN;
    cfg_wdata <= mouse;
    @(posedge clk);
    sb.set_register(REG_MOUSE_EN, mouse);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // non-button mouse byte, zero delta a quarter of the time
  function automatic logic [7:0] mouse_delta();
    logic [7:0] v;
    if ($urandom_range(0, 3) == 0) return {7'd0, 1'($urandom)};
    v = 8'($urandom);
    while (v[7:4] == BTN_NIBBLE) v = 8'($urandom);
    return v;
  endfunction

  // mostly delta y, button, delta x sequences, some noise
  task automatic random_samples(int count);
    logic [7:0] kb;
    logic [7:0] ms;
    for (int i = 0; i < count; i++) begin
      kb = $urandom_range(0, 1) ? kb_sent : 8'($urandom);
      if ($urandom_range(0, 99) < 75) begin
        if (seq_pos == 1) begin
          ms = {BTN_NIBBLE, 4'($urandom)};
        end else begin
          ms = mouse_delta();
        end
        seq_pos = (seq_pos + 1) % 3;
      end else begin
        ms = 8'($urandom);
      end
      send_sample(kb, ms);
    end
  endtask

  // run watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("parallel_kbd_mouse_decoder_unit test failed");
    $finish;
  end

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_enables(1'b1, 1'b1);
    foreach (DIRECTED[i]) send_sample(DIRECTED[i][7:0], DIRECTED[i][15:8]);
    random_samples(RANDOM_PER_SETTING);

    set_enables(1'b0, 1'b1);
    random_samples(RANDOM_PER_SETTING);

    set_enables(1'b1, 1'b0);
    random_samples(RANDOM_PER_SETTING);

    set_enables(1'b0, 1'b0);
    random_samples(RANDOM_PER_SETTING);

    // final setting runs both sides without stalls
    set_enables(1'b1, 1'b1);
    steady = 1'b1;
    random_samples(RANDOM_PER_SETTING);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d port samples over %0d enable settings, %0d output bytes checked",
             samples, settings, sb.checked);
    $display("%0d mouse reports sent, %0d unchanged reports held back",
             sb.reports, sb.dropped);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("parallel_kbd_mouse_decoder_unit test passed");
    end else begin
      $display("parallel_kbd_mouse_decoder_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pkmd_pkg.sv
sv/pkmd_front.sv
sv/pkmd_fifo.sv
sv/pkmd_back.sv
sv/parallel_kbd_mouse_decoder_unit.sv
verif/parallel_kbd_mouse_decoder_unit_tb.sv
